// ===== design/yin_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YIN pitch detector package
// Shared constants, payload types and status structs for the pitch detector.
// ----------------------------------------------------------------------------
package yin_pkg;

    localparam int SAMPLE_BITS      = 16;
    localparam int WINDOW_DEPTH_DEF = 4096;
    localparam int MAX_LAG_DEF      = 512;

    localparam int SQ_W      = 2 * SAMPLE_BITS;
    localparam int D_W       = 48;
    localparam int DN_W      = 18;
    localparam int DIV_QB    = 18;
    localparam int DIV_DW    = 48;
    localparam int LAG_OUT_W = 11;
    localparam int CFG_W     = 17;
    localparam int CFG_AW    = 3;

    localparam logic [DN_W-1:0] DN_ONE  = 18'd65536;
    localparam logic [DN_W-1:0] DN_CAP  = 18'h3FFFF;
    localparam logic [D_W-1:0]  SUM_CAP = {D_W{1'b1}};

    localparam logic [15:0] THRESHOLD_RST = 16'd6554;
    localparam logic [9:0]  MIN_LAG_RST   = 10'd16;
    localparam logic [16:0] RATE_RST      = 17'd16000;
    localparam logic [11:0] MIN_PITCH_RST = 12'd50;
    localparam logic [11:0] MAX_PITCH_RST = 12'd1000;

    typedef enum logic [CFG_AW-1:0] {
        REG_THRESHOLD   = 3'd0,
        REG_MIN_LAG     = 3'd1,
        REG_SAMPLE_RATE = 3'd2,
        REG_MIN_PITCH   = 3'd3,
        REG_MAX_PITCH   = 3'd4
    } cfg_reg_t;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
    } yin_in_t;

    typedef struct packed {
        logic        voiced;
        logic [15:0] pitch_hz_q4;
        logic [10:0] chosen_lag;
    } yin_out_t;

    typedef struct packed {
        logic clear;
        logic bus_valid;
        logic unload;
    } yin_cell_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic ovf;
    } yin_div_stat_t;

endpackage

// ===== design/yin_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module yin_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== design/yin_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YIN difference cell
// Holds one delayed sample and accumulates the squared difference for one lag;
// the accumulators shift toward the head of the chain for readout.
// ----------------------------------------------------------------------------
module yin_cell (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  yin_pkg::yin_cell_ctrl_t  ctrl,
    input  yin_pkg::sample_t         x_bus,
    input  yin_pkg::sample_t         tap_in,
    input  logic                     tap_valid_in,
    output yin_pkg::sample_t         tap_out,
    output logic                     tap_valid_out,
    input  logic [yin_pkg::D_W-1:0]  acc_in,
    output logic [yin_pkg::D_W-1:0]  acc_out
);
    import yin_pkg::*;

    sample_t                   tap_reg;
    logic                      tap_valid_reg;
    logic                      prod_valid_reg;
    logic [SQ_W-1:0]           sq_reg;
    logic [D_W-1:0]            acc_reg;
    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [2*SAMPLE_BITS+1:0] prod;

    assign diff = (SAMPLE_BITS+1)'(x_bus) - (SAMPLE_BITS+1)'(tap_reg);
    assign prod = diff * diff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
        end else if (ctrl.clear) begin
            tap_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
        end else begin
            if (ctrl.bus_valid) begin
                tap_valid_reg <= tap_valid_in;
            end
            prod_valid_reg <= ctrl.bus_valid & tap_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.bus_valid) begin
            tap_reg <= tap_in;
        end
        sq_reg <= prod[SQ_W-1:0];
        if (ctrl.clear) begin
            acc_reg <= '0;
        end else if (ctrl.unload) begin
            acc_reg <= acc_in;
        end else if (prod_valid_reg) begin
            acc_reg <= acc_reg + D_W'(sq_reg);
        end
    end

    assign tap_out       = tap_reg;
    assign tap_valid_out = tap_valid_reg;
    assign acc_out       = acc_reg;
endmodule

// ===== design/yin_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YIN serial divider
// Restoring divider giving one quotient bit per cycle; flags quotients that
// do not fit in the quotient width.
// ----------------------------------------------------------------------------
module yin_div #(
    parameter int NW = 69,
    parameter int DW = 48
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [NW-1:0]               num,
    input  logic [DW-1:0]               den,
    output logic [yin_pkg::DIV_QB-1:0]  quo,
    output yin_pkg::yin_div_stat_t      stat
);
    import yin_pkg::*;

    localparam int HW    = NW - DIV_QB;
    localparam int CW    = (HW > DW) ? HW : DW;
    localparam int CNT_W = $clog2(DIV_QB + 1);

    logic              busy_reg;
    logic              done_reg;
    logic              ovf_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DW-1:0]     rem_reg;
    logic [DW-1:0]     den_reg;
    logic [DIV_QB-1:0] low_reg;
    logic [DIV_QB-1:0] quo_reg;
    logic [HW-1:0]     high;
    logic              ovf_now;
    logic [DW:0]       trial;
    logic [DW:0]       trial_sub;
    logic              ge;

    assign high      = num[NW-1:DIV_QB];
    assign ovf_now   = CW'(high) >= CW'(den);
    assign trial     = {rem_reg, low_reg[DIV_QB-1]};
    assign trial_sub = trial - {1'b0, den_reg};
    assign ge        = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                ovf_reg <= ovf_now;
                if (ovf_now) begin
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= CNT_W'(DIV_QB);
                end
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= DW'(high);
            den_reg <= den;
            low_reg <= num[DIV_QB-1:0];
        end else if (busy_reg) begin
            rem_reg <= ge ? trial_sub[DW-1:0] : trial[DW-1:0];
            low_reg <= {low_reg[DIV_QB-2:0], 1'b0};
            quo_reg <= {quo_reg[DIV_QB-2:0], ge};
        end
    end

    assign quo       = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.ovf  = ovf_reg;
endmodule

// ===== design/yin_pitch_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YIN pitch detector
// Loads audio samples into a ring, runs the YIN difference function over a
// chain of lag cells and reports the refined pitch of the newest window.
// ----------------------------------------------------------------------------
// Usage:
// Samples arrive on the s_ channel, one transaction per cycle while loading.
// A transaction with last set stores its sample and starts an analysis; the
// input channel is held off until the result has been formed. Each analysis
// gives exactly one transaction on the m_ channel.
// Analysis after the last sample: half of the stored samples are streamed
// from the ring into the cell chain (one ring read per cycle), then each of
// the MAX_LAG lags is normalized in the shared serial divider, then the
// interpolation and pitch division follow. With fewer than 2*MAX_LAG samples
// no difference function is run and an unvoiced result is given.
// The result sits in an output register; a stalled receiver does not stop
// loading of new samples, but the next result waits until it has gone.
// Reset clears the sample count, ring pointer and configuration to defaults;
// the ring contents are not cleared. Configuration writes take effect at once.
// ----------------------------------------------------------------------------
module yin_pitch_detector #(
    parameter int WINDOW_DEPTH = yin_pkg::WINDOW_DEPTH_DEF,
    parameter int MAX_LAG      = yin_pkg::MAX_LAG_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  yin_pkg::yin_in_t            s_payload,
    output logic                        m_valid,
    input  logic                        m_ready,
    output yin_pkg::yin_out_t           m_payload,
    input  logic                        cfg_wr_en,
    input  logic [yin_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [yin_pkg::CFG_W-1:0]   cfg_wdata
);
    import yin_pkg::*;

    localparam int  AW       = $clog2(WINDOW_DEPTH);
    localparam int  CNT_W    = $clog2(WINDOW_DEPTH + 1);
    localparam int  LAG_W    = $clog2(MAX_LAG + 1);
    localparam int  NUM_W    = D_W + LAG_W;
    localparam int  DIV_NW   = NUM_W + 16;
    localparam int  ABS_W    = DN_W + 2;
    localparam int  M1_W     = CFG_W + ABS_W;
    localparam int  M2_W     = ABS_W + LAG_W;
    localparam int  DD_W     = M2_W + 3;
    localparam bit  HAS_ROOM = WINDOW_DEPTH >= 2 * MAX_LAG;

    typedef enum logic [11:0] {
        S_LOAD   = 12'b0000_0000_0001,
        S_START  = 12'b0000_0000_0010,
        S_STREAM = 12'b0000_0000_0100,
        S_DRAIN  = 12'b0000_0000_1000,
        S_NSUM   = 12'b0000_0001_0000,
        S_NDIV   = 12'b0000_0010_0000,
        S_NWAIT  = 12'b0000_0100_0000,
        S_PDEN   = 12'b0000_1000_0000,
        S_PMUL   = 12'b0001_0000_0000,
        S_PSEL   = 12'b0010_0000_0000,
        S_PWAIT  = 12'b0100_0000_0000,
        S_OUT    = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] thr_reg;
    logic [9:0]  min_lag_reg;
    logic [16:0] sr_reg;
    logic [11:0] min_pitch_reg;
    logic [11:0] max_pitch_reg;

    logic [AW-1:0]    wp_reg;
    logic [CNT_W-1:0] count_reg;
    logic [AW-1:0]    rp_reg;
    logic [CNT_W-1:0] rd_cnt_reg;
    logic [CNT_W-1:0] half_reg;
    logic [1:0]       drain_reg;
    logic             rd_valid_reg;

    logic [LAG_W-1:0] lag_reg;
    logic [D_W-1:0]   running_sum_reg;
    logic [NUM_W-1:0] num_reg;
    logic             cum_zero_reg;

    logic             found_reg;
    logic             follow_reg;
    logic [LAG_W-1:0] best_reg;
    logic [DN_W-1:0]  best_val_reg;
    logic [DN_W-1:0]  s0_reg;
    logic [DN_W-1:0]  s2_reg;
    logic [DN_W-1:0]  prev_reg;

    logic signed [DN_W+2:0] den_reg;
    logic                   interp_reg;
    logic                   den_neg_reg;
    logic [M1_W-1:0]        m1_reg;
    logic [M2_W-1:0]        m2_reg;
    logic signed [DN_W+1:0] diff_reg;

    logic        res_voiced_reg;
    logic [15:0] res_pitch_reg;
    logic        m_valid_reg;
    yin_out_t    m_payload_reg;

    logic             s_fire;
    logic             rd_issue;
    logic [CNT_W:0]   wp_ext;
    logic [CNT_W:0]   cnt_ext;
    logic [CNT_W:0]   start_wide;
    logic             enough;
    logic [D_W:0]     sum_wide;
    logic [D_W-1:0]   cum;
    logic             dn_ready;
    logic [DN_W-1:0]  dn_val;
    logic [ABS_W-1:0] den_abs;
    logic signed [DD_W-1:0] dd;
    logic             use_interp;
    logic             last_lag;
    logic [DIV_QB-1:0] quo;
    logic             pitch_ok;

    logic                div_start;
    logic [DIV_NW-1:0]   div_num;
    logic [DIV_DW-1:0]   div_den;
    yin_div_stat_t       div_stat;

    logic [SAMPLE_BITS-1:0] ram_rdata;
    yin_cell_ctrl_t         cell_ctrl;
    sample_t                tap_w       [MAX_LAG];
    logic                   tap_valid_w [MAX_LAG];
    logic [D_W-1:0]         acc_w       [MAX_LAG];

    assign s_fire   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_LOAD);
    assign rd_issue = (state_reg == S_STREAM) && (rd_cnt_reg != half_reg);

    assign wp_ext     = (CNT_W+1)'(wp_reg);
    assign cnt_ext    = (CNT_W+1)'(count_reg);
    assign start_wide = (wp_ext >= cnt_ext) ? wp_ext - cnt_ext
                      : wp_ext + (CNT_W+1)'(WINDOW_DEPTH) - cnt_ext;
    assign enough     = HAS_ROOM && (32'(count_reg) >= 2 * MAX_LAG);

    assign sum_wide = {1'b0, running_sum_reg} + {1'b0, acc_w[0]};
    assign cum      = sum_wide[D_W] ? SUM_CAP : sum_wide[D_W-1:0];

    assign dn_ready = ((state_reg == S_NWAIT) && div_stat.done)
                   || ((state_reg == S_NDIV) && cum_zero_reg);
    assign dn_val   = cum_zero_reg ? DN_ONE : (div_stat.ovf ? DN_CAP : quo);
    assign last_lag = (32'(lag_reg) == MAX_LAG);

    assign den_abs = den_reg[DN_W+2] ? ABS_W'(-den_reg) : ABS_W'(den_reg);
    assign dd      = $signed({2'b00, m2_reg, 1'b0})
                   + (den_neg_reg ? -DD_W'(diff_reg) : DD_W'(diff_reg));
    assign use_interp = interp_reg && !dd[DD_W-1] && (dd != '0);

    assign pitch_ok = !div_stat.ovf && (quo != '0)
                   && (quo >= DIV_QB'({min_pitch_reg, 4'b0000}))
                   && (quo <= DIV_QB'({max_pitch_reg, 4'b0000}));

    always_comb begin
        div_start = 1'b0;
        div_num   = DIV_NW'({num_reg, 16'h0000});
        div_den   = DIV_DW'(running_sum_reg);
        if (state_reg == S_NDIV) begin
            div_start = !cum_zero_reg;
        end else if (state_reg == S_PSEL) begin
            div_start = 1'b1;
            if (use_interp) begin
                div_num = DIV_NW'({m1_reg, 6'b000000}) + DIV_NW'(dd[DD_W-2:0]);
                div_den = DIV_DW'({dd[DD_W-2:0], 1'b0});
            end else begin
                div_num = DIV_NW'({sr_reg, 5'b00000}) + DIV_NW'(best_reg);
                div_den = DIV_DW'({best_reg, 1'b0});
            end
        end
    end

    assign cell_ctrl.clear     = (state_reg == S_START);
    assign cell_ctrl.bus_valid = rd_valid_reg;
    assign cell_ctrl.unload    = dn_ready;

    yin_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (s_fire),
        .wr_addr (wp_reg),
        .wr_data (s_payload.sample),
        .rd_en   (rd_issue),
        .rd_addr (rp_reg),
        .rd_data (ram_rdata)
    );

    generate
        for (genvar k = 0; k < MAX_LAG; k++) begin : g_cell
            sample_t        tap_src;
            logic           tap_valid_src;
            logic [D_W-1:0] acc_src;
            if (k == 0) begin : g_head
                assign tap_src       = $signed(ram_rdata);
                assign tap_valid_src = 1'b1;
            end else begin : g_body
                assign tap_src       = tap_w[k-1];
                assign tap_valid_src = tap_valid_w[k-1];
            end
            if (k == MAX_LAG - 1) begin : g_tail
                assign acc_src = '0;
            end else begin : g_link
                assign acc_src = acc_w[k+1];
            end
            yin_cell u_cell (
                .aclk          (aclk),
                .aresetn       (aresetn),
                .ctrl          (cell_ctrl),
                .x_bus         ($signed(ram_rdata)),
                .tap_in        (tap_src),
                .tap_valid_in  (tap_valid_src),
                .tap_out       (tap_w[k]),
                .tap_valid_out (tap_valid_w[k]),
                .acc_in        (acc_src),
                .acc_out       (acc_w[k])
            );
        end
    endgenerate

    yin_div #(
        .NW (DIV_NW),
        .DW (DIV_DW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .quo     (quo),
        .stat    (div_stat)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD: begin
                if (s_fire && s_payload.last) begin
                    state_next = S_START;
                end
            end
            S_START:  state_next = enough ? S_STREAM : S_OUT;
            S_STREAM: begin
                if (rd_cnt_reg == half_reg) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (drain_reg == 2'd2) begin
                    state_next = S_NSUM;
                end
            end
            S_NSUM: state_next = S_NDIV;
            S_NDIV: begin
                if (cum_zero_reg) begin
                    state_next = last_lag ? S_PDEN : S_NSUM;
                end else begin
                    state_next = S_NWAIT;
                end
            end
            S_NWAIT: begin
                if (div_stat.done) begin
                    state_next = last_lag ? S_PDEN : S_NSUM;
                end
            end
            S_PDEN:  state_next = found_reg ? S_PMUL : S_OUT;
            S_PMUL:  state_next = S_PSEL;
            S_PSEL:  state_next = S_PWAIT;
            S_PWAIT: begin
                if (div_stat.done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg) begin
                    state_next = S_LOAD;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg       <= THRESHOLD_RST;
            min_lag_reg   <= MIN_LAG_RST;
            sr_reg        <= RATE_RST;
            min_pitch_reg <= MIN_PITCH_RST;
            max_pitch_reg <= MAX_PITCH_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_THRESHOLD:   thr_reg       <= cfg_wdata[15:0];
                REG_MIN_LAG:     min_lag_reg   <= cfg_wdata[9:0];
                REG_SAMPLE_RATE: sr_reg        <= cfg_wdata[16:0];
                REG_MIN_PITCH:   min_pitch_reg <= cfg_wdata[11:0];
                REG_MAX_PITCH:   max_pitch_reg <= cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg          <= '0;
            count_reg       <= '0;
            rd_valid_reg    <= 1'b0;
            running_sum_reg <= '0;
            found_reg       <= 1'b0;
            follow_reg      <= 1'b0;
            res_voiced_reg  <= 1'b0;
            res_pitch_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            rd_valid_reg <= rd_issue;
            if (s_fire) begin
                wp_reg <= (wp_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                if (count_reg != CNT_W'(WINDOW_DEPTH)) begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (state_reg == S_START) begin
                found_reg      <= 1'b0;
                follow_reg     <= 1'b0;
                res_voiced_reg <= 1'b0;
                res_pitch_reg  <= '0;
                if (enough) begin
                    running_sum_reg <= '0;
                end
            end
            if (state_reg == S_NSUM) begin
                running_sum_reg <= cum;
            end
            if (dn_ready) begin
                if (!found_reg) begin
                    if ((32'(lag_reg) >= 32'(min_lag_reg))
                            && (dn_val < DN_W'(thr_reg))) begin
                        found_reg  <= 1'b1;
                        follow_reg <= 1'b1;
                    end
                end else if (follow_reg && !(dn_val < best_val_reg)) begin
                    follow_reg <= 1'b0;
                end
            end
            if ((state_reg == S_PWAIT) && div_stat.done) begin
                res_voiced_reg <= pitch_ok;
                res_pitch_reg  <= pitch_ok ? quo[15:0] : 16'h0000;
            end
            if ((state_reg == S_OUT) && !m_valid_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_START) begin
            rp_reg     <= start_wide[AW-1:0];
            rd_cnt_reg <= '0;
            half_reg   <= count_reg >> 1;
            lag_reg    <= LAG_W'(1);
            prev_reg   <= DN_ONE;
        end
        if (rd_issue) begin
            rp_reg     <= (rp_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            rd_cnt_reg <= rd_cnt_reg + 1'b1;
        end
        if (state_reg == S_STREAM) begin
            drain_reg <= '0;
        end else if (state_reg == S_DRAIN) begin
            drain_reg <= drain_reg + 1'b1;
        end
        if (state_reg == S_NSUM) begin
            num_reg      <= NUM_W'(acc_w[0]) * NUM_W'(lag_reg);
            cum_zero_reg <= (cum == '0);
        end
        if (dn_ready) begin
            prev_reg <= dn_val;
            lag_reg  <= lag_reg + 1'b1;
            if (!found_reg) begin
                if ((32'(lag_reg) >= 32'(min_lag_reg))
                        && (dn_val < DN_W'(thr_reg))) begin
                    best_reg     <= lag_reg;
                    best_val_reg <= dn_val;
                    s0_reg       <= prev_reg;
                end
            end else if (follow_reg) begin
                if (dn_val < best_val_reg) begin
                    best_reg     <= lag_reg;
                    best_val_reg <= dn_val;
                    s0_reg       <= prev_reg;
                end else begin
                    s2_reg <= dn_val;
                end
            end
        end
        if (state_reg == S_PDEN) begin
            den_reg <= $signed({3'b000, s0_reg}) - $signed({2'b00, best_val_reg, 1'b0})
                     + $signed({3'b000, s2_reg});
            interp_reg <= (32'(best_reg) > 32'(min_lag_reg))
                       && (32'(best_reg) < MAX_LAG);
        end
        if (state_reg == S_PMUL) begin
            m1_reg      <= M1_W'(sr_reg) * M1_W'(den_abs);
            m2_reg      <= M2_W'(den_abs) * M2_W'(best_reg);
            diff_reg    <= $signed({2'b00, s0_reg}) - $signed({2'b00, s2_reg});
            den_neg_reg <= den_reg[DN_W+2];
            interp_reg  <= interp_reg && (den_reg != '0);
        end
        if ((state_reg == S_OUT) && !m_valid_reg) begin
            m_payload_reg.voiced      <= res_voiced_reg;
            m_payload_reg.pitch_hz_q4 <= res_pitch_reg;
            m_payload_reg.chosen_lag  <= found_reg ? LAG_OUT_W'(best_reg) : '0;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    a_voiced_has_lag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.voiced) |-> (m_payload.chosen_lag != '0))
        else $error("voiced result without a chosen lag");

    a_unvoiced_zero_pitch: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_payload.voiced) |-> (m_payload.pitch_hz_q4 == '0))
        else $error("unvoiced result with nonzero pitch");

    a_div_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_lag_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_NSUM) |-> ((lag_reg != '0) && (32'(lag_reg) <= MAX_LAG)))
        else $error("lag counter out of range");

    a_stream_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_NSUM) |-> (rd_cnt_reg == half_reg))
        else $error("normalization started before the window was streamed");
endmodule
